/* hdl/b64e_pkg.sv */
// base64 stream encoder package: shared types, constants and the sextet alphabet
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package b64e_pkg;

  localparam int B64E_FIFO_DEPTH = 4;
  localparam int B64E_MAX_CHARS  = 4;

  localparam logic [7:0] B64E_PAD     = 8'h3D;  // '='
  localparam logic [7:0] B64E_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] B64E_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] B64E_DIGIT_0 = 8'h30;  // '0'
  localparam logic [7:0] B64E_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] B64E_SLASH   = 8'h2F;  // '/'

  // characters caused by one input byte, with the index of the last one
  typedef struct packed {
    logic [B64E_MAX_CHARS-1:0][7:0] chars;
    logic [1:0]                     last_idx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      sextet_char = B64E_UPPER_A + v8;
    end else if (v < 6'd52) begin
      sextet_char = B64E_LOWER_A + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      sextet_char = B64E_DIGIT_0 + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      sextet_char = B64E_PLUS;
    end else begin
      sextet_char = B64E_SLASH;
    end
  endfunction

endpackage

/* hdl/b64e_in_if.sv */
// input channel of the base64 encoder: one raw byte and its final flag
// no dependencies
`timescale 1ns / 1ps

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

/* hdl/b64e_out_if.sv */
// result channel of the base64 encoder: one ascii character per transaction
// no dependencies
`timescale 1ns / 1ps

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

/* hdl/b64e_front.sv */
// front end: accepts bytes, tracks group phase and pending bits, builds jobs
// depends on b64e_pkg and b64e_in_if
`timescale 1ns / 1ps

module b64e_front
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  b64e_in_if.sink     in_ch,
  input  fifo_stat_t  fifo_stat,
  output logic        push,
  output job_t        push_job
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [3:0] pend_r, pend_nxt;
  logic [7:0] b;
  logic       fin;

  assign in_ch.ready = !fifo_stat.full;
  assign push        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign fin         = in_ch.final_byte;

  always_comb begin
    push_job.chars    = {B64E_MAX_CHARS{B64E_PAD}};
    push_job.last_idx = 2'd0;
    phase_nxt         = phase_r;
    pend_nxt          = pend_r;
    case (phase_r)
      PH_SECOND: begin
        push_job.chars[0] = sextet_char({pend_r[1:0], b[7:4]});
        push_job.chars[1] = sextet_char({b[3:0], 2'b00});
        push_job.last_idx = fin ? 2'd2 : 2'd0;
        phase_nxt         = PH_THIRD;
        pend_nxt          = b[3:0];
      end
      PH_THIRD: begin
        push_job.chars[0] = sextet_char({pend_r, b[7:6]});
        push_job.chars[1] = sextet_char(b[5:0]);
        push_job.last_idx = 2'd1;
        phase_nxt         = PH_FIRST;
        pend_nxt          = 4'd0;
      end
      default: begin
        push_job.chars[0] = sextet_char(b[7:2]);
        push_job.chars[1] = sextet_char({b[1:0], 4'b0000});
        push_job.last_idx = fin ? 2'd3 : 2'd0;
        phase_nxt         = PH_SECOND;
        pend_nxt          = {2'b00, b[1:0]};
      end
    endcase
    // final byte ends the message, next byte opens a new one
    if (fin) begin
      phase_nxt = PH_FIRST;
      pend_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      pend_r  <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

/* hdl/b64e_fifo.sv */
// job queue between front and back end, register based
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_fifo
  import b64e_pkg::*;
#(
  parameter int DEPTH = B64E_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  job_t       push_job,
  input  logic       pop,
  output job_t       pop_job,
  output fifo_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_job    = mem_r[rd_ptr_r];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* hdl/b64e_back.sv */
// back end: takes jobs from the queue and sends their characters one per cycle while out_ch is ready
// depends on b64e_pkg and b64e_out_if
`timescale 1ns / 1ps

module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fifo_stat_t  fifo_stat,
  input  job_t        pop_job,
  output logic        pop,
  b64e_out_if.source  out_ch
);

  job_t       cur_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       is_last;
  logic       done;

  assign is_last         = (idx_r == cur_r.last_idx);
  assign done            = busy_r && out_ch.ready && is_last;
  // refill in the same cycle the last character of a job leaves
  assign pop             = !fifo_stat.empty && (!busy_r || done);

  assign out_ch.valid    = busy_r;
  assign out_ch.out_char = cur_r.chars[idx_r];
  assign out_ch.run_last = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      if (pop) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (busy_r && out_ch.ready) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_job;
    end
  end

endmodule

/* hdl/base64_stream_encoder.sv */
// channel  | dir | payload                      | transaction
// in_ch    | in  | data_byte[7:0], final_byte   | one raw byte
// out_ch   | out | out_char[7:0], run_last      | one base64 character or pad
//
// a byte is taken every cycle while the job queue has room; each byte yields 1 to 4
// characters, sent by the back end one per cycle while out_ch is ready, with no gap
// between jobs, so a long stream runs at 4 characters per 3 bytes (output port bound).
// the first character is offered once the byte has passed through the job queue and
// into the back end's current-job register. rst_n is synchronous and needs no
// clearing pass. the queue lets input and output stall on their own.
// depends on b64e_pkg, b64e_in_if, b64e_out_if, b64e_front, b64e_fifo, b64e_back
`timescale 1ns / 1ps

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int FIFO_DEPTH = B64E_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  b64e_in_if.sink    in_ch,
  b64e_out_if.source out_ch
);

  fifo_stat_t fifo_stat;
  logic       push, pop;
  job_t       push_job, pop_job;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_job  (push_job)
  );

  b64e_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (fifo_stat)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

/* hdl/b64e_checker.sv */
// port level checks on the base64 encoder, bound to the top level
// depends on b64e_pkg and base64_stream_encoder
`timescale 1ns / 1ps

module b64e_checker
  import b64e_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       run_last
);

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_last))
    else $error("result changed while stalled");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !run_last |=> out_valid)
    else $error("gap inside the characters of one byte");

  a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && out_char == B64E_PAD && !run_last |=> out_valid && out_char == B64E_PAD)
    else $error("pad followed by a data character");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= 8'h41 && out_char <= 8'h5A) ||
                  (out_char >= 8'h61 && out_char <= 8'h7A) ||
                  (out_char >= 8'h30 && out_char <= 8'h39) ||
                  out_char == B64E_PLUS || out_char == B64E_SLASH ||
                  out_char == B64E_PAD)
    else $error("character outside the base64 alphabet");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .run_last  (out_ch.run_last)
);

/* tb/sv/base64_stream_encoder_tb.sv */
// testbench for base64_stream_encoder: directed and random byte messages,
// encoded characters checked in order against a behavioral encoder
// depends on b64e_pkg, b64e_in_if, b64e_out_if and the block itself
`timescale 1ns / 1ps

module base64_stream_encoder_tb;
  import b64e_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int OPENING_LEN  = 20;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } b64_char_t;

  // behavioral encoder plus the queue of characters still owed by the block
  class b64_scoreboard;
    logic [1:0] phase;
    logic [3:0] held_bits;
    b64_char_t  char_q[$];
    int         errors;
    string      alphabet;

    function new();
      phase     = 2'd0;
      held_bits = 4'd0;
      errors    = 0;
      alphabet  = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    endfunction

    function void push_char(logic [7:0] c);
      b64_char_t e;
      e.ch   = c;
      e.last = 1'b0;
      char_q = {char_q, e};
    endfunction

    function void push_sextet(logic [5:0] v);
      push_char(alphabet[v]);
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      case (phase)
        2'd1: begin
          push_sextet({held_bits[1:0], b[7:4]});
          held_bits = b[3:0];
          phase     = 2'd2;
          if (fin) begin
            push_sextet({held_bits, 2'b00});
            push_char(B64E_PAD);
          end
        end
        2'd2: begin
          push_sextet({held_bits, b[7:6]});
          push_sextet(b[5:0]);
          held_bits = 4'd0;
          phase     = 2'd0;
        end
        default: begin
          push_sextet(b[7:2]);
          held_bits = {2'b00, b[1:0]};
          phase     = 2'd1;
          if (fin) begin
            push_sextet({b[1:0], 4'b0000});
            push_char(B64E_PAD);
            push_char(B64E_PAD);
          end
        end
      endcase
      if (fin) begin
        phase     = 2'd0;
        held_bits = 4'd0;
      end
      char_q[char_q.size()-1].last = 1'b1;
    endfunction

    function void check_char(logic [7:0] c, logic last);
      b64_char_t e;
      if (char_q.size() == 0) begin
        $display("%0t: unexpected character expected none actual %h run_last %b",
                 $time, c, last);
        errors++;
        return;
      end
      e = char_q.pop_front();
      if (c !== e.ch) begin
        $display("%0t: out_char mismatch expected %h actual %h", $time, e.ch, c);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: run_last mismatch expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return char_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   send_max;
  int   recv_max;
  bit   hold_req;

  b64_scoreboard sb = new();

  b64e_in_if  in_ch();
  b64e_out_if out_ch();

  base64_stream_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // {final, byte}: single-byte, two-byte and three-byte messages, longer ones
  logic [8:0] opening_bytes [OPENING_LEN] = '{
    9'h100,
    9'h1FF,
    9'h0FF, 9'h100,
    9'h0FB, 9'h0FF, 9'h1BF,
    9'h000, 9'h010, 9'h183,
    9'h04D, 9'h061, 9'h06E, 9'h120,
    9'h0AA, 9'h155,
    9'h055, 9'h0AA, 9'h055, 9'h1AA
  };

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // transaction monitors
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      sb.note_byte(in_ch.data_byte, in_ch.final_byte);
    end
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_char(out_ch.out_char, out_ch.run_last);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = $urandom_range(0, send_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_messages(input int count);
    int         left;
    int         len;
    logic [7:0] b;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 12);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, i == len - 1);
      end
      left -= len;
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int idle;
    wait (rst_n === 1'b1);
    forever begin
      idle = hold_req ? HOLD_CYCLES : $urandom_range(0, recv_max);
      if (idle > 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      hold_req = 1'b0;
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin
    cycle_count       = 0;
    send_max          = 3;
    recv_max          = 3;
    hold_req          = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.final_byte <= 1'b0;
    out_ch.ready     <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < OPENING_LEN; i++) begin
      send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin send_max = 0;  recv_max = 0;  end
        1: begin send_max = 18; recv_max = 18; end
        2: begin send_max = 0;  recv_max = 18; end
        3: begin send_max = 18; recv_max = 0;  end
        4: begin send_max = 0;  recv_max = 0;  hold_req = 1'b1; end
        default: begin send_max = 4; recv_max = 4; end
      endcase
      send_messages(48);
    end
    in_ch.valid <= 1'b0;
    // let the monitor note the last transaction before watching the queue
    @(posedge clk);

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: missing characters expected %0d actual 0", $time, sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/b64e_pkg.sv
hdl/b64e_in_if.sv
hdl/b64e_out_if.sv
hdl/b64e_front.sv
hdl/b64e_fifo.sv
hdl/b64e_back.sv
hdl/base64_stream_encoder.sv
hdl/b64e_checker.sv
tb/sv/base64_stream_encoder_tb.sv
